@@ src/sict_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to decimal text: shared package
// Constants, state encoding and the control types between the top level and
// the binary-to-BCD converter.
// ----------------------------------------------------------------------------
package sict_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned BcdWidth   = NumDigits * DigitWidth;
  localparam int unsigned CharWidth  = 6;
  localparam int unsigned BitCntWidth   = $clog2(ValueWidth);
  localparam int unsigned DigitCntWidth = $clog2(NumDigits + 1);

  localparam logic [CharWidth-1:0]  CharZero  = CharWidth'(48);
  localparam logic [CharWidth-1:0]  CharMinus = CharWidth'(45);
  localparam logic [DigitWidth-1:0] DabbleMin = DigitWidth'(5);
  localparam logic [DigitWidth-1:0] DabbleAdd = DigitWidth'(3);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SKIP = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  typedef struct packed {
    logic                  start;
    logic [ValueWidth-1:0] magnitude;
  } conv_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [BcdWidth-1:0] bcd;
  } conv_rsp_t;

endpackage

@@ src/sict_bcd_conv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial binary to BCD converter
// Shifts the magnitude in one bit per cycle, most significant first, and
// corrects every BCD digit on the way (shift and add three).
// ----------------------------------------------------------------------------
module sict_bcd_conv
  import sict_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  conv_req_t req_i,
  output conv_rsp_t rsp_o
);

  logic [ValueWidth-1:0]  mag_q, mag_d;
  logic [BcdWidth-1:0]    bcd_q, bcd_d;
  logic [BcdWidth-1:0]    bcd_adj;
  logic [BitCntWidth-1:0] cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic                   last_bit;

  assign last_bit = (cnt_q == BitCntWidth'(ValueWidth - 1));

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*DigitWidth +: DigitWidth] >= DabbleMin) begin
        bcd_adj[i*DigitWidth +: DigitWidth] = bcd_q[i*DigitWidth +: DigitWidth] + DabbleAdd;
      end else begin
        bcd_adj[i*DigitWidth +: DigitWidth] = bcd_q[i*DigitWidth +: DigitWidth];
      end
    end
  end

  always_comb begin
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      mag_d  = req_i.magnitude;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      mag_d = {mag_q[ValueWidth-2:0], 1'b0};
      bcd_d = {bcd_adj[BcdWidth-2:0], mag_q[ValueWidth-1]};
      if (last_bit) begin
        cnt_d  = '0;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + BitCntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.bcd  = bcd_q;

  a_idle_cnt_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cnt_q == '0))
    else $error("Bit counter is nonzero while the converter is idle.");

  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !req_i.start) |=> !done_q)
    else $error("Conversion done lasts longer than one cycle.");

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q)
    else $error("Converter did not start after a start request.");

endmodule

@@ src/signed_int_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII text
// Converts one signed 32-bit value to its decimal characters, sign first,
// most significant digit first, without leading zeros.
// ----------------------------------------------------------------------------
// After a request is taken, the magnitude is converted to BCD bit-serially,
// suppressed leading zeros are shifted out one at a time, then the characters follow.
// A new request is taken only in idle, after the last character has been sent;
// characters go out one per cycle while out_ready_i is high.
// Reset: asynchronous, active low; returns the controller to idle, no data kept.
module signed_int_to_decimal_ascii
  import sict_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ValueWidth-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CharWidth-1:0]  text_char_o,
  output logic                  last_char_o
);

  state_e                   state_q, state_d;
  logic                     neg_q, neg_d;
  logic [BcdWidth-1:0]      digits_q, digits_d;
  logic [DigitCntWidth-1:0] left_q, left_d;
  logic [DigitWidth-1:0]    top_digit;
  logic                     in_accept;
  logic                     out_accept;
  conv_req_t                conv_req;
  conv_rsp_t                conv_rsp;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_SIGN) || (state_q == S_EMIT);
  assign out_accept  = out_valid_o && out_ready_i;
  assign top_digit   = digits_q[BcdWidth-1 -: DigitWidth];

  assign conv_req.start     = in_accept;
  assign conv_req.magnitude = value_i[ValueWidth-1] ? (ValueWidth'(0) - value_i) : value_i;

  sict_bcd_conv u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (conv_req),
    .rsp_o  (conv_rsp)
  );

  always_comb begin
    if (state_q == S_SIGN) begin
      text_char_o = CharMinus;
      last_char_o = 1'b0;
    end else begin
      text_char_o = CharZero | CharWidth'(top_digit);
      last_char_o = (left_q == DigitCntWidth'(1));
    end
  end

  always_comb begin
    state_d  = state_q;
    neg_d    = neg_q;
    digits_d = digits_q;
    left_d   = left_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          neg_d   = value_i[ValueWidth-1];
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        if (conv_rsp.done) begin
          digits_d = conv_rsp.bcd;
          left_d   = DigitCntWidth'(NumDigits);
          state_d  = S_SKIP;
        end
      end
      S_SKIP: begin
        if ((top_digit == '0) && (left_q > DigitCntWidth'(1))) begin
          digits_d = {digits_q[BcdWidth-DigitWidth-1:0], DigitWidth'(0)};
          left_d   = left_q - DigitCntWidth'(1);
        end else if (neg_q) begin
          state_d = S_SIGN;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_SIGN: begin
        if (out_accept) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_accept) begin
          digits_d = {digits_q[BcdWidth-DigitWidth-1:0], DigitWidth'(0)};
          left_d   = left_q - DigitCntWidth'(1);
          if (left_q == DigitCntWidth'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q    <= neg_d;
    digits_q <= digits_d;
  end

  a_accept_to_conv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_CONV))
    else $error("Controller did not enter conversion after a request.");

  a_emit_has_digits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (left_q != '0))
    else $error("Emitting a character with no digits left.");

  a_conv_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_rsp.busy |-> (state_q == S_CONV))
    else $error("Converter is busy outside the conversion state.");

  a_out_not_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("Input taken while characters are still being sent.");

endmodule

@@ tb/tb_signed_int_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench: signed integer to decimal ASCII text
// Sends signed 32-bit values through the request channel and checks every
// character on the output channel against a predicted character stream,
// including the minus sign and the end mark. Both channels pause at random,
// except during the closing streaming test.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;
  import sict_pkg::*;

  localparam int unsigned Radix      = 10;
  localparam int          CycleLimit = 400000;
  localparam int          MaxPrinted = 40;

  typedef struct packed {
    logic [CharWidth-1:0] text_char;
    logic                 last_char;
  } text_char_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [ValueWidth-1:0] value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [CharWidth-1:0]  text_char_o;
  logic                  last_char_o;

  text_char_t expected_chars[$];
  int         error_count;
  int         cycle_count;
  bit         pauses_on;

  signed_int_to_decimal_ascii DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void queue_decimal_text(input logic [ValueWidth-1:0] value);
    logic [ValueWidth-1:0] magnitude;
    logic [DigitWidth-1:0] digits[NumDigits];
    int                    num_digits;
    magnitude  = value[ValueWidth-1] ? (~value + ValueWidth'(1)) : value;
    num_digits = 0;
    do begin
      digits[num_digits] = DigitWidth'(magnitude % Radix);
      magnitude          = magnitude / Radix;
      num_digits++;
    end while (magnitude != 0 && num_digits < NumDigits);
    if (value[ValueWidth-1]) begin
      expected_chars.push_back('{CharMinus, 1'b0});
    end
    for (int i = num_digits - 1; i >= 0; i--) begin
      expected_chars.push_back('{CharZero + CharWidth'(digits[i]), i == 0});
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MaxPrinted) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    error_count++;
  endtask

  // Between requests the valid line is lowered only here, so a request that follows
  // directly keeps it high without a second assignment in the same step.
  task automatic pause_requests();
    if (pauses_on && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_value(input logic [ValueWidth-1:0] value);
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    queue_decimal_text(value);
    pause_requests();
  endtask

  function automatic logic [ValueWidth-1:0] random_value_of_length();
    int unsigned num_digits;
    longint      low_mag;
    longint      high_mag;
    longint      magnitude;
    bit          negative;
    num_digits = $urandom_range(1, NumDigits);
    negative   = 1'($urandom_range(0, 1));
    low_mag    = (num_digits == 1) ? 0 : 1;
    high_mag   = 9;
    for (int i = 1; i < num_digits; i++) begin
      low_mag  = (i == 1) ? 10 : low_mag * 10;
      high_mag = high_mag * 10 + 9;
    end
    if (high_mag > 64'sd2147483648) begin
      high_mag = negative ? 64'sd2147483648 : 64'sd2147483647;
    end
    case ($urandom_range(0, 7))
      0: magnitude = low_mag;
      1: magnitude = high_mag;
      default: magnitude = low_mag + longint'($urandom) % (high_mag - low_mag + 1);
    endcase
    return negative ? ValueWidth'(-magnitude) : ValueWidth'(magnitude);
  endfunction

  task automatic test_directed_values();
    logic [ValueWidth-1:0] directed[$];
    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd9, -32'sd10, 32'd99, 32'd100,
                 32'd999999999, 32'd1000000000, -32'sd999999999, -32'sd1000000000,
                 32'd2147483647, 32'h8000_0000, 32'h8000_0001, 32'd1234567890,
                 -32'sd1234567890, 32'd1000000007, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7};
    foreach (directed[i]) begin
      send_value(directed[i]);
    end
  endtask

  task automatic test_random_lengths();
    repeat (200) send_value(random_value_of_length());
  endtask

  task automatic test_random_full_range();
    repeat (150) send_value($urandom);
  endtask

  task automatic test_streaming();
    pauses_on = 1'b0;
    repeat (60) begin
      if ($urandom_range(0, 1) == 0) begin
        send_value($urandom);
      end else begin
        send_value(random_value_of_length());
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    out_ready_i = 1'b0;
    error_count = 0;
    pauses_on   = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_values();
    test_random_lengths();
    test_random_full_range();
    test_streaming();

    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pauses_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_text
    text_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected character", int'(text_char_o), -1);
      end else begin
        want = expected_chars.pop_front();
        if (text_char_o !== want.text_char) begin
          report_mismatch("text_char", int'(text_char_o), int'(want.text_char));
        end
        if (last_char_o !== want.last_char) begin
          report_mismatch("last_char", int'(last_char_o), int'(want.last_char));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d characters outstanding", cycle_count,
               expected_chars.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
